### hdl/pid_power_to_pwm_duty_top_macros.svh
// ----------------------------------------------------------------------------
// PID power-to-PWM assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PID_POWER_TO_PWM_DUTY_TOP_MACROS_SVH
`define PID_POWER_TO_PWM_DUTY_TOP_MACROS_SVH

// same-cycle implication
`define PIDPWM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PIDPWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pidpwm_pkg.sv
// ----------------------------------------------------------------------------
// PID power-to-PWM package
// Field widths, accumulator limits, reset values and register indexes.
// ----------------------------------------------------------------------------
package pidpwm_pkg;

    localparam int GAIN_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int SUM_W      = 32;
    localparam int Y_W        = 42;
    localparam int OFFSET_W   = 12;
    localparam int HEAT_OUT_W = 12;
    localparam int DUTY_OUT_W = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [SUM_W-1:0] SUM_MAX = 32'h7FFF_FFFF;

    localparam logic [GAIN_W-1:0]   GAIN_PROP_RST    = 8'd1;
    localparam logic [GAIN_W-1:0]   GAIN_INTEG_RST   = 8'd0;
    localparam logic [GAIN_W-1:0]   GAIN_DERIV_RST   = 8'd0;
    localparam logic [OFFSET_W-1:0] POWER_OFFSET_RST = 12'd300;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN_PROP    = 2'd0,
        CFG_GAIN_INTEG   = 2'd1,
        CFG_GAIN_DERIV   = 2'd2,
        CFG_POWER_OFFSET = 2'd3
    } cfg_index_t;

endpackage

### hdl/pidpwm_mac.sv
// ----------------------------------------------------------------------------
// PID bit-serial multiply-accumulate
// Forms kp*e + ki*sum + kd*diff, one gain bit per cycle, three terms in turn.
// ----------------------------------------------------------------------------
module pidpwm_mac (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [pidpwm_pkg::SAMPLE_W-1:0]    sample,
    input  logic        [pidpwm_pkg::SUM_W-1:0]       integ,
    input  logic signed [pidpwm_pkg::DIFF_W-1:0]      diff,
    input  logic        [pidpwm_pkg::GAIN_W-1:0]      gain_prop,
    input  logic        [pidpwm_pkg::GAIN_W-1:0]      gain_integ,
    input  logic        [pidpwm_pkg::GAIN_W-1:0]      gain_deriv,
    output logic                                      done,
    output logic signed [pidpwm_pkg::Y_W-1:0]         y
);
    import pidpwm_pkg::*;

    localparam int BIT_CNT_W = $clog2(GAIN_W);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(GAIN_W - 1);

    typedef enum logic [2:0] {
        TERM_P = 3'b001,
        TERM_I = 3'b010,
        TERM_D = 3'b100
    } term_t;

    term_t                  term_reg, term_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic signed [Y_W-1:0]  acc_reg, acc_next;
    logic signed [Y_W-1:0]  mcand_reg, mcand_next;
    logic [GAIN_W-1:0]      mult_reg, mult_next;
    logic [SUM_W-1:0]       integ_reg, integ_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [GAIN_W-1:0]      gi_reg, gi_next;
    logic [GAIN_W-1:0]      gd_reg, gd_next;

    always_comb
    begin
        term_next    = term_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mult_next    = mult_reg;
        integ_next   = integ_reg;
        diff_next    = diff_reg;
        gi_next      = gi_reg;
        gd_next      = gd_reg;

        if (start)
        begin
            acc_next     = '0;
            mcand_next   = {{(Y_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
            mult_next    = gain_prop;
            integ_next   = integ;
            diff_next    = diff;
            gi_next      = gain_integ;
            gd_next      = gain_deriv;
            term_next    = TERM_P;
            bit_cnt_next = '0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mult_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next   = mcand_reg << 1;
            mult_next    = mult_reg >> 1;
            bit_cnt_next = bit_cnt_reg + 1'b1;

            // last gain bit of this term: load the next term's operands, or finish after the D term
            if (bit_cnt_reg == BIT_LAST)
            begin
                bit_cnt_next = '0;
                unique case (term_reg)
                    TERM_P:
                    begin
                        term_next  = TERM_I;
                        mcand_next = {{(Y_W-SUM_W){1'b0}}, integ_reg};
                        mult_next  = gi_reg;
                    end
                    TERM_I:
                    begin
                        term_next  = TERM_D;
                        mcand_next = {{(Y_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                        mult_next  = gd_reg;
                    end
                    TERM_D:
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    default:
                    begin
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg    <= TERM_P;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            term_reg    <= term_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        integ_reg <= integ_next;
        diff_reg  <= diff_next;
        gi_reg    <= gi_next;
        gd_reg    <= gd_next;
    end

    assign done = done_reg;
    assign y    = acc_reg;

endmodule

### hdl/pidpwm_div.sv
// ----------------------------------------------------------------------------
// PID constant divider
// Restoring division by a fixed divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidpwm_div #(
    parameter int DVD_W   = 23,
    parameter int Q_W     = 11,
    parameter int DIVISOR = 3000
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    output logic             done,
    output logic [Q_W-1:0]   quotient
);
    import pidpwm_pkg::*;

    localparam int DVS_W = $clog2(DIVISOR + 1);
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [DVS_W:0]   DVS_EXT   = (DVS_W+1)'(DIVISOR);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;   // dividend shifts out, quotient in
    logic [DVS_W:0]   trial;
    logic             q_bit;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign q_bit = (trial >= DVS_EXT);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_START;
            rem_next  = '0;
            dvd_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (q_bit)
            begin
                rem_next = DVS_W'(trial - DVS_EXT);
            end
            else
            begin
                rem_next = DVS_W'(trial);
            end
            dvd_next = {dvd_reg[DVD_W-2:0], q_bit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[Q_W-1:0];

endmodule

### hdl/pid_power_to_pwm_duty_top.sv
// ----------------------------------------------------------------------------
// PID power-to-PWM duty controller
// Flow: a sample is accepted only in IDLE and passes the serial gain-bit MAC
//   and the serial duty divider; no new sample is taken until the result is
//   parked in the output register, and parking waits while it is full and unread.
// Reset: async active low; gains 1/0/0, offset 300, integral and last sample 0.
// ----------------------------------------------------------------------------
`include "pid_power_to_pwm_duty_top_macros.svh"

module pid_power_to_pwm_duty_top #(
    parameter int MAX_LOAD   = 3000,
    parameter int DUTY_RANGE = 1024
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // configuration write port
    input  logic                                        cfg_wr_en,
    input  logic        [pidpwm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic        [pidpwm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // sample channel
    input  logic                                        sample_valid,
    output logic                                        sample_ready,
    input  logic signed [pidpwm_pkg::SAMPLE_W-1:0]      grid_power,
    // result channel
    output logic                                        result_valid,
    input  logic                                        result_ready,
    output logic        [pidpwm_pkg::HEAT_OUT_W-1:0]    heater_power,
    output logic        [pidpwm_pkg::DUTY_OUT_W-1:0]    pwm_duty
);
    import pidpwm_pkg::*;

    // Heater power fits HEAT_W bits after the clamp; the duty product
    // heat * DUTY_RANGE fits PROD_W bits; the quotient never exceeds DUTY_RANGE.
    localparam int HEAT_W = $clog2(MAX_LOAD + 1);
    localparam int RANGE_W = $clog2(DUTY_RANGE + 1);
    localparam int PROD_W = HEAT_W + RANGE_W;

    localparam logic [HEAT_W-1:0]   HEAT_MAX   = HEAT_W'(MAX_LOAD);
    localparam logic [Y_W:0]        HSUM_LIMIT = (Y_W+1)'(MAX_LOAD);
    localparam logic [SAMPLE_W:0]   WIN_LIMIT  = (SAMPLE_W+1)'(MAX_LOAD);
    localparam logic [PROD_W-1:0]   RANGE_EXT  = PROD_W'(DUTY_RANGE);

    // Item flow: accept in IDLE, start MAC, wait, start divider, wait,
    // then park the result in the output register once it is free or being read.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_MAC  = 6'b000100,
        S_DIVS = 6'b001000,
        S_DIV  = 6'b010000,
        S_WB   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [GAIN_W-1:0]   gain_prop_reg, gain_prop_next;
    logic [GAIN_W-1:0]   gain_integ_reg, gain_integ_next;
    logic [GAIN_W-1:0]   gain_deriv_reg, gain_deriv_next;
    logic [OFFSET_W-1:0] power_offset_reg, power_offset_next;

    // controller state
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;

    // per-item operands and intermediate results
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic [HEAT_W-1:0]          heat_reg, heat_next;

    // output register
    logic                    result_valid_reg, result_valid_next;
    logic [HEAT_OUT_W-1:0]   heater_power_reg, heater_power_next;
    logic [DUTY_OUT_W-1:0]   pwm_duty_reg, pwm_duty_next;

    // sample-side arithmetic
    logic              in_window;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_sat;

    // PID output and heater clamp
    logic                  mac_done;
    logic signed [Y_W-1:0] mac_y;
    logic [Y_W-1:0]        y_mag;
    logic [Y_W:0]          hsum;
    logic [HEAT_W-1:0]     heat_calc;

    // duty division
    logic                  div_done;
    logic [PROD_W-1:0]     dividend;
    logic [RANGE_W-1:0]    quotient;

    // ------------------------------------------------------------------------
    // Configuration writes: user writes only while idle; not enforced.
    // ------------------------------------------------------------------------
    always_comb
    begin
        gain_prop_next    = gain_prop_reg;
        gain_integ_next   = gain_integ_reg;
        gain_deriv_next   = gain_deriv_reg;
        power_offset_next = power_offset_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_GAIN_PROP:    gain_prop_next    = cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_INTEG:   gain_integ_next   = cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_DERIV:   gain_deriv_next   = cfg_wdata[GAIN_W-1:0];
                CFG_POWER_OFFSET: power_offset_next = cfg_wdata[OFFSET_W-1:0];
                default:          gain_prop_next    = gain_prop_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Integral window: 0 < sample < MAX_LOAD. The sum only ever grows and
    // saturates at the largest 32-bit signed value, so its top bit stays 0.
    // ------------------------------------------------------------------------
    assign in_window = !grid_power[SAMPLE_W-1] && (grid_power != '0) &&
                       ({2'b00, grid_power[SAMPLE_W-2:0]} < WIN_LIMIT);
    assign sum_add   = {1'b0, sum_reg} + (SUM_W+1)'(grid_power[SAMPLE_W-2:0]);
    assign sum_sat   = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];

    // ------------------------------------------------------------------------
    // Heater demand: zero for a non-negative PID value, otherwise
    // -y + offset clamped to MAX_LOAD.
    // ------------------------------------------------------------------------
    assign y_mag = ~mac_y + 1'b1;
    assign hsum  = {1'b0, y_mag} + (Y_W+1)'(power_offset_reg);

    always_comb
    begin
        if (!mac_y[Y_W-1])
        begin
            heat_calc = '0;
        end
        else if (hsum > HSUM_LIMIT)
        begin
            heat_calc = HEAT_MAX;
        end
        else
        begin
            heat_calc = hsum[HEAT_W-1:0];
        end
    end

    // constant multiply; the divider registers the product on start
    assign dividend = PROD_W'(heat_reg) * RANGE_EXT;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        sum_next          = sum_reg;
        prev_next         = prev_reg;
        sample_next       = sample_reg;
        diff_next         = diff_reg;
        heat_next         = heat_reg;
        result_valid_next = result_valid_reg;
        heater_power_next = heater_power_reg;
        pwm_duty_next     = pwm_duty_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    sample_next = grid_power;
                    diff_next   = {grid_power[SAMPLE_W-1], grid_power} -
                                  {prev_reg[SAMPLE_W-1], prev_reg};
                    prev_next   = grid_power;
                    if (in_window)
                    begin
                        sum_next = sum_sat;
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (mac_done)
                begin
                    heat_next  = heat_calc;
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // output register free, or being emptied this cycle
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    heater_power_next = HEAT_OUT_W'(heat_reg);
                    pwm_duty_next     = DUTY_OUT_W'(quotient);
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            gain_prop_reg    <= GAIN_PROP_RST;
            gain_integ_reg   <= GAIN_INTEG_RST;
            gain_deriv_reg   <= GAIN_DERIV_RST;
            power_offset_reg <= POWER_OFFSET_RST;
            sum_reg          <= '0;
            prev_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            gain_prop_reg    <= gain_prop_next;
            gain_integ_reg   <= gain_integ_next;
            gain_deriv_reg   <= gain_deriv_next;
            power_offset_reg <= power_offset_next;
            sum_reg          <= sum_next;
            prev_reg         <= prev_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg       <= sample_next;
        diff_reg         <= diff_next;
        heat_reg         <= heat_next;
        heater_power_reg <= heater_power_next;
        pwm_duty_reg     <= pwm_duty_next;
    end

    // ------------------------------------------------------------------------
    // Serial units
    // ------------------------------------------------------------------------
    pidpwm_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (state_reg == S_LOAD),
        .sample     (sample_reg),
        .integ      (sum_reg),
        .diff       (diff_reg),
        .gain_prop  (gain_prop_reg),
        .gain_integ (gain_integ_reg),
        .gain_deriv (gain_deriv_reg),
        .done       (mac_done),
        .y          (mac_y)
    );

    pidpwm_div #(
        .DVD_W   (PROD_W),
        .Q_W     (RANGE_W),
        .DIVISOR (MAX_LOAD)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIVS),
        .dividend (dividend),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign heater_power = heater_power_reg;
    assign pwm_duty     = pwm_duty_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `PIDPWM_ASSERT_IMPL(a_sum_nonneg, 1'b1, !sum_reg[SUM_W-1], "integral went negative")
    `PIDPWM_ASSERT_IMPL(a_mac_done_state, mac_done, state_reg == S_MAC, "MAC done out of step")
    `PIDPWM_ASSERT_IMPL(a_heat_clamped, state_reg == S_WB, heat_reg <= HEAT_MAX, "heat above max load")
    `PIDPWM_ASSERT_NEXT(a_div_to_wb, div_done && state_reg == S_DIV, state_reg == S_WB, "no writeback after divide")

endmodule
